FILE: src/srb_pkg.sv
// Package for the scan rectangle boundary block: widths, register indexes,
// fixed-point constants and back-end state type. No dependencies.
`default_nettype none
package srb_pkg;
	localparam int unsigned DefMaxPoints = 4096;
	localparam int unsigned DefRangeBits = 16;
	localparam int unsigned CfgAddrW = 3;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned PptW = 13;
	localparam int unsigned IdxW = 12;

	localparam logic [CfgAddrW-1:0] RegFront = 3'd0;
	localparam logic [CfgAddrW-1:0] RegSide = 3'd1;
	localparam logic [CfgAddrW-1:0] RegPpt = 3'd2;
	localparam logic [CfgAddrW-1:0] RegStart = 3'd3;
	localparam logic [CfgAddrW-1:0] RegEnd = 3'd4;
	localparam logic [CfgAddrW-1:0] RegCorner = 3'd5;

	localparam logic [28:0] Q28One = 29'h1000_0000;
	localparam logic [31:0] HalfPiQ28 = 32'd421657428;

	// Reciprocals that give exact quotients of values below 2^30 by the series
	// denominators: ceil(2^(30+k) / d), with 2^k the power of two at or above d.
	localparam logic [30:0] Recip90 = 31'd1527099484;
	localparam logic [30:0] Recip56 = 31'd1227133514;
	localparam logic [30:0] Recip30 = 31'd1145324613;
	localparam logic [30:0] Recip12 = 31'd1431655766;

	typedef enum logic [2:0] {
		BK_IDLE, BK_PHASE, BK_COS, BK_DIV, BK_DONE
	} bk_state_t;
endpackage
`default_nettype wire

FILE: src/srb_front.sv
// Front end: counts samples within the turn and classifies each one as pass
// or replace. Uses srb_pkg.
`default_nettype none
module srb_front #(
	parameter int unsigned MAX_POINTS = srb_pkg::DefMaxPoints,
	parameter int unsigned RANGE_BITS = srb_pkg::DefRangeBits,
	localparam int unsigned IW = $clog2(MAX_POINTS)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_take,
	input  wire logic [RANGE_BITS-1:0] range_in,
	input  wire logic                  last_of_scan,
	input  wire logic [11:0]           sector_start,
	input  wire logic [12:0]           sector_end,
	input  wire logic [12:0]           corner_index,
	output logic [RANGE_BITS+IW+2:0]   cmd
);
	import srb_pkg::*;
	logic [IW-1:0] idx_q;
	logic in_sec, use_side;

	always_comb begin
		in_sec = ({{(IW+1){1'b0}}, sector_start} <= {{(13){1'b0}}, idx_q}) &&
		         ({{(13){1'b0}}, idx_q} < {{(IW){1'b0}}, sector_end});
		use_side = !({{(13){1'b0}}, idx_q} < {{(IW){1'b0}}, corner_index});
		// word: range, last, replace, side edge, index
		cmd = {range_in, last_of_scan, in_sec, use_side, idx_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (in_take) begin
			if (last_of_scan) idx_q <= '0;
			else idx_q <= idx_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

FILE: src/srb_queue.sv
// Two-entry queue of words between the front and the back parts.
// No package dependency.
`default_nettype none
module srb_queue #(
	parameter int unsigned W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              empty
);
	logic [W-1:0] mem_q [2];
	logic rp_q, wp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= 1'b0;
			wp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push && !full} - {1'b0, pop && !empty};
		end
	end
endmodule
`default_nettype wire

FILE: src/srb_back.sv
// Back end: phase division, cosine series and distance division for replaced
// samples, ahead of a one-word result register. Uses srb_pkg.
`default_nettype none
module srb_back #(
	parameter int unsigned MAX_POINTS = srb_pkg::DefMaxPoints,
	parameter int unsigned RANGE_BITS = srb_pkg::DefRangeBits,
	localparam int unsigned IW = $clog2(MAX_POINTS),
	localparam int unsigned CW = RANGE_BITS + IW + 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_empty,
	input  wire logic [CW-1:0]         q_data,
	output logic                       q_pop,
	input  wire logic [15:0]           front_distance,
	input  wire logic [15:0]           side_distance,
	input  wire logic [12:0]           points_per_turn,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [RANGE_BITS-1:0]      range_out,
	output logic                       last_out
);
	import srb_pkg::*;
	localparam int unsigned PSteps = IW + 32;
	localparam logic [RANGE_BITS-1:0] RMax = '1;

	bk_state_t st_q, st_d;
	logic [RANGE_BITS-1:0] rng_q;
	logic last_q, rep_q, side_q;
	logic [IW-1:0] dvd_q;
	logic [5:0] cnt_q;
	logic [12:0] prem_q;      // partial remainder of phase division
	logic [30:0] phase_q;
	logic [12:0] ppt_q;
	logic [3:0] ci_q;
	logic [29:0] x_q, x2_q, pr_q, num_q, quo_q;
	logic [28:0] t_q;
	logic [14:0] trig_q;
	logic [14:0] drem_q;
	logic out_v_q;
	logic [RANGE_BITS-1:0] out_r_q;
	logic out_l_q;

	logic load_out;
	logic [13:0] ptry;
	logic [30:0] fv;
	logic [59:0] mul_x, mul_xx;
	logic [58:0] mul_xt;
	logic [60:0] mul_r;
	logic [29:0] r_src, r_quo;
	logic [30:0] r_mul;
	logic [28:0] p_half, t_fin, t_rnd;
	logic [15:0] dtry;
	logic [15:0] edge_dist;
	logic [29:0] dnum;

	always_comb begin
		ptry = {prem_q, dvd_q[IW-1]};
		// the mirrored quarter is taken when quadrant parity and edge differ
		fv = (phase_q[30] ^ side_q) ? 31'h4000_0000 - {1'b0, phase_q[29:0]}
			: {1'b0, phase_q[29:0]};
		mul_x = 60'(fv) * 60'(HalfPiQ28);
		mul_xx = 60'(x_q) * 60'(x_q);
		mul_xt = 59'(x2_q) * 59'(t_q);
		r_src = (ci_q == 4'd2) ? x2_q : pr_q;
		unique case (ci_q)
			4'd2:    r_mul = Recip90;
			4'd4:    r_mul = Recip56;
			4'd6:    r_mul = Recip30;
			default: r_mul = Recip12;
		endcase
		mul_r = 61'(r_src) * 61'(r_mul);
		unique case (ci_q)
			4'd2:    r_quo = 30'(mul_r >> 37);
			4'd4:    r_quo = 30'(mul_r >> 36);
			4'd6:    r_quo = 30'(mul_r >> 35);
			default: r_quo = 30'(mul_r >> 34);
		endcase
		p_half = pr_q[29:1];
		t_fin = (p_half >= Q28One) ? '0 : Q28One - p_half;
		t_rnd = t_fin + 29'd8192;
		dtry = {drem_q, num_q[29]};
		edge_dist = side_q ? side_distance : front_distance;
		dnum = {edge_dist, 14'd0} + 30'(trig_q[14:1]);
		load_out = (st_q == BK_DONE) && (!out_v_q || pop);
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE:  if (!q_empty) st_d = q_data[IW+1] ? BK_PHASE : BK_DONE;
			BK_PHASE: if (cnt_q == 6'd0) st_d = BK_COS;
			BK_COS:   if (ci_q == 4'd11) st_d = BK_DIV;
			BK_DIV:   if (cnt_q == 6'd0) st_d = BK_DONE;
			BK_DONE:  if (!out_v_q || pop) st_d = BK_IDLE;
			default:  st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (st_q == BK_IDLE) && !q_empty;
	end

	assign empty = !out_v_q;
	assign range_out = out_r_q;
	assign last_out = out_l_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			out_v_q <= load_out ? 1'b1 : (out_v_q && !pop);
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			BK_IDLE: begin
				rng_q <= q_data[CW-1:IW+3];
				last_q <= q_data[IW+2];
				rep_q <= q_data[IW+1];
				side_q <= q_data[IW];
				dvd_q <= q_data[IW-1:0];
				ppt_q <= (points_per_turn == 13'd0) ? 13'd1 : points_per_turn;
				prem_q <= '0;
				cnt_q <= 6'(PSteps - 1);
			end
			BK_PHASE: begin
				// restoring division of index << 32 by ppt; the low 32 quotient
				// bits are the phase of (index mod ppt)
				if (ptry >= {1'b0, ppt_q}) begin
					prem_q <= 13'(ptry - {1'b0, ppt_q});
					phase_q <= {phase_q[29:0], 1'b1};
				end else begin
					prem_q <= ptry[12:0];
					phase_q <= {phase_q[29:0], 1'b0};
				end
				dvd_q <= {dvd_q[IW-2:0], 1'b0};
				cnt_q <= cnt_q - 6'd1;
				ci_q <= '0;
			end
			BK_COS: begin
				unique case (ci_q)
					4'd0: x_q <= mul_x[59:30];
					4'd1: x2_q <= mul_xx[57:28];
					4'd2, 4'd4, 4'd6, 4'd8: t_q <= Q28One - 29'(r_quo);
					4'd3, 4'd5, 4'd7, 4'd9: pr_q <= mul_xt[57:28];
					4'd10: trig_q <= t_rnd[28:14];
					default: begin
						num_q <= dnum;
						drem_q <= '0;
						quo_q <= '0;
						cnt_q <= 6'd29;
					end
				endcase
				ci_q <= ci_q + 4'd1;
			end
			BK_DIV: begin
				if (dtry >= {1'b0, trig_q}) begin
					drem_q <= 15'(dtry - {1'b0, trig_q});
					quo_q <= {quo_q[28:0], 1'b1};
				end else begin
					drem_q <= dtry[14:0];
					quo_q <= {quo_q[28:0], 1'b0};
				end
				num_q <= {num_q[28:0], 1'b0};
				cnt_q <= cnt_q - 6'd1;
			end
			BK_DONE: begin
				if (load_out) begin
					out_l_q <= last_q;
					priority if (!rep_q) out_r_q <= rng_q;
					else if (trig_q == 15'd0) out_r_q <= RMax;
					else if ({34'd0, quo_q} > 64'(RMax)) out_r_q <= RMax;
					else out_r_q <= RANGE_BITS'(quo_q);
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

FILE: src/scan_rectangle_boundary.sv
// Top level of the scan rectangle boundary block: registers, front part,
// queue and back part. Uses srb_pkg, srb_front, srb_queue, srb_back.
//
// channel   direction  handshake         word
// input     in         push / full       range_in, last_of_scan
// result    out        pop / empty       range_out, last_out
// config    in         cfg_we            cfg_index, cfg_data
//
// With the back part free, a replaced sample that is accepted is taken from the
// queue, goes through the phase division, the cosine series and the distance
// division, and is loaded into the result register. A passed sample skips the
// arithmetic and goes from the queue straight to the result register.
// Reset clears the counter, the queue and the result register and returns the
// registers to their defaults. The back part holds while the result register
// is full and pop is low; the front part stalls once the two-entry queue fills.
`default_nettype none
module scan_rectangle_boundary #(
	parameter int unsigned MAX_POINTS = srb_pkg::DefMaxPoints,
	parameter int unsigned RANGE_BITS = srb_pkg::DefRangeBits
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [RANGE_BITS-1:0]         range_in,
	input  wire logic                          last_of_scan,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [RANGE_BITS-1:0]              range_out,
	output logic                               last_out,
	input  wire logic                          cfg_we,
	input  wire logic [srb_pkg::CfgAddrW-1:0]  cfg_index,
	input  wire logic [srb_pkg::CfgDataW-1:0]  cfg_data
);
	import srb_pkg::*;
	localparam int unsigned IW = $clog2(MAX_POINTS);
	localparam int unsigned CW = RANGE_BITS + IW + 3;

	logic [15:0] front_q, side_q;
	logic [12:0] ppt_q, end_q, corner_q;
	logic [11:0] start_q;
	logic [CW-1:0] cmd, q_data;
	logic q_empty, q_pop;

	// Configuration registers: user writes while block is idle; unchecked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= 16'd2000;
			side_q <= 16'd2000;
			ppt_q <= 13'd360;
			start_q <= 12'd0;
			end_q <= 13'd90;
			corner_q <= 13'd45;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegFront:  front_q <= cfg_data;
				RegSide:   side_q <= cfg_data;
				RegPpt:    ppt_q <= cfg_data[12:0];
				RegStart:  start_q <= cfg_data[11:0];
				RegEnd:    end_q <= cfg_data[12:0];
				RegCorner: corner_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	srb_front #(.MAX_POINTS(MAX_POINTS), .RANGE_BITS(RANGE_BITS)) u_front (
		.clk, .arst_n, .in_take(push && !full), .range_in, .last_of_scan,
		.sector_start(start_q), .sector_end(end_q), .corner_index(corner_q), .cmd
	);

	srb_queue #(.W(CW)) u_queue (
		.clk, .arst_n, .push, .wdata(cmd), .full,
		.pop(q_pop), .rdata(q_data), .empty(q_empty)
	);

	srb_back #(.MAX_POINTS(MAX_POINTS), .RANGE_BITS(RANGE_BITS)) u_back (
		.clk, .arst_n, .q_empty, .q_data, .q_pop,
		.front_distance(front_q), .side_distance(side_q), .points_per_turn(ppt_q),
		.empty, .pop, .range_out, .last_out
	);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		empty == 1'b0 && !pop |=> $stable(range_out))
		else $error("result changed while waiting");
	a_stay: assert property (@(posedge clk) disable iff (!arst_n)
		empty == 1'b0 && !pop |=> empty == 1'b0)
		else $error("result word dropped while waiting");
	a_qpop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");
endmodule
`default_nettype wire
